FILE: sv/tea_pkg.sv
// Shared types, constants and round-sum helpers for the TEA cipher pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tea_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned NumCycles = 32;
  localparam int unsigned NumStages = 2 * NumCycles;

  typedef logic [WordW-1:0]   word_t;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam word_t Delta    = 32'h9E37_79B9;
  localparam word_t DecStart = 32'hC6EF_3720;

  // Configuration register indexes.
  localparam cfg_idx_t CfgKey0 = 4'd0;
  localparam cfg_idx_t CfgKey1 = 4'd1;
  localparam cfg_idx_t CfgKey2 = 4'd2;
  localparam cfg_idx_t CfgKey3 = 4'd3;

  // Operation select carried by each block.
  localparam logic KindEncrypt = 1'b0;
  localparam logic KindDecrypt = 1'b1;

  typedef struct packed {
    logic  kind;
    word_t block_left;
    word_t block_right;
  } in_item_t;

  typedef struct packed {
    word_t result_left;
    word_t result_right;
  } out_item_t;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  typedef struct packed {
    logic  kind;
    word_t left;
    word_t right;
  } stage_t;

  // Round sum used by encryption cycle cyc (sum is advanced before the cycle).
  function automatic word_t enc_sum(input int unsigned cyc);
    return word_t'(Delta * word_t'(cyc + 1));
  endfunction

  // Round sum used by decryption cycle cyc (sum is retired after the cycle).
  function automatic word_t dec_sum(input int unsigned cyc);
    return word_t'(DecStart - Delta * word_t'(cyc));
  endfunction

endpackage

`default_nettype wire

FILE: sv/tea_key_regs.sv
// Key register file: four 32-bit key words written over the configuration channel.
// Depends on tea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tea_key_regs import tea_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire cfg_idx_t cfg_index_i,
  input  wire word_t    cfg_data_i,
  output key_t          key_o
);

  key_t key_d, key_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    key_d = key_q;
    if (cfg_valid_i) begin
      // Writes to an index beyond the key words are dropped.
      unique case (cfg_index_i)
        CfgKey0: key_d.k0 = cfg_data_i;
        CfgKey1: key_d.k1 = cfg_data_i;
        CfgKey2: key_d.k2 = cfg_data_i;
        CfgKey3: key_d.k3 = cfg_data_i;
        default: key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

`default_nettype wire

FILE: sv/tea_half_round.sv
// One registered Feistel half-round of TEA, for both encryption and decryption.
// Depends on tea_pkg; instantiated once per pipeline stage by tea_block_cipher.
`timescale 1ns / 1ps
`default_nettype none

module tea_half_round import tea_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   second_half_i,
  input  wire word_t  sum_enc_i,
  input  wire word_t  sum_dec_i,
  input  wire key_t   key_i,
  input  wire logic   valid_i,
  input  wire stage_t data_i,
  output logic        valid_o,
  output stage_t      data_o
);

  logic   upd_left;
  word_t  w, s, ka, kb, mix, tgt, res;
  stage_t data_d, data_q;
  logic   valid_q;

  // Encryption updates left then right; decryption runs the halves reversed.
  assign upd_left = (data_i.kind == KindEncrypt) ? !second_half_i : second_half_i;

  always_comb begin
    w   = upd_left ? data_i.right : data_i.left;
    tgt = upd_left ? data_i.left  : data_i.right;
    ka  = upd_left ? key_i.k0 : key_i.k2;
    kb  = upd_left ? key_i.k1 : key_i.k3;
    s   = (data_i.kind == KindDecrypt) ? sum_dec_i : sum_enc_i;
    mix = ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
    res = (data_i.kind == KindDecrypt) ? (tgt - mix) : (tgt + mix);
    data_d      = data_i;
    if (upd_left) begin
      data_d.left = res;
    end else begin
      data_d.right = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

FILE: sv/tea_block_cipher.sv
// TEA block cipher of 32 round pairs, as a 64-stage half-round pipeline with a key register file.
// Depends on tea_pkg, tea_key_regs and tea_half_round.
//
//   Channel   Direction  Handshake                   Payload
//   in        input      in_valid_i / in_ready_o     in_item_i  (kind, block_left, block_right)
//   out       output     out_valid_o / out_ready_i   out_item_o (result_left, result_right)
//   cfg       input      cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// One block enters per cycle while the output is not stalled. There is one pipeline stage per
// Feistel half-round, and the last stage is the output register; a block passes through all
// of them before its result is valid at the output.
// Reset clears every stage valid bit and the four key words to zero.
// A stalled output freezes all stages together, so nothing is lost or repeated.
// Configuration writes are accepted every cycle.
`timescale 1ns / 1ps
`default_nettype none

module tea_block_cipher import tea_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o,
  input  wire logic     cfg_valid_i,
  output logic          cfg_ready_o,
  input  wire cfg_idx_t cfg_index_i,
  input  wire word_t    cfg_data_i
);

  key_t   key;
  logic   en;
  logic   stage_valid [NumStages+1];
  stage_t stage_data  [NumStages+1];

  tea_key_regs u_key_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .key_o       (key)
  );

  // The whole pipeline advances unless a finished result is waiting and the output is not ready.
  assign en         = !stage_valid[NumStages] || out_ready_i;
  assign in_ready_o = en;

  assign stage_valid[0]      = in_valid_i;
  assign stage_data[0].kind  = in_item_i.kind;
  assign stage_data[0].left  = in_item_i.block_left;
  assign stage_data[0].right = in_item_i.block_right;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    tea_half_round u_round (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (en),
      .second_half_i (1'(g % 2)),
      .sum_enc_i     (enc_sum(g / 2)),
      .sum_dec_i     (dec_sum(g / 2)),
      .key_i         (key),
      .valid_i       (stage_valid[g]),
      .data_i        (stage_data[g]),
      .valid_o       (stage_valid[g+1]),
      .data_o        (stage_data[g+1])
    );
  end

  assign out_valid_o             = stage_valid[NumStages];
  assign out_item_o.result_left  = stage_data[NumStages].left;
  assign out_item_o.result_right = stage_data[NumStages].right;

  // An accepted block occupies the first stage in the next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> stage_valid[1])
    else $error("accepted block did not enter the pipeline");

  // A stall leaves the occupancy of the final stages untouched.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> stage_valid[NumStages] && stage_valid[NumStages-1] == $past(stage_valid[NumStages-1]))
    else $error("pipeline moved during a stall");

  // When the pipeline advances, the output stage takes the valid bit of the stage before it.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> stage_valid[NumStages] == $past(stage_valid[NumStages-1]))
    else $error("valid bit lost or duplicated at the output stage");

  // The operation select travels unchanged with its block.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && stage_valid[NumStages-1] |=>
      stage_data[NumStages].kind == $past(stage_data[NumStages-1].kind))
    else $error("kind bit changed inside the pipeline");

endmodule

`default_nettype wire

FILE: tb/tea_checker.sv
// Scoreboard for the TEA block cipher: watches the input, output and key-write channels,
// predicts each result from its own copy of the key, and counts mismatches.
// Depends on tea_pkg for the payload types, the round constant and the register indexes.
`timescale 1ns / 1ps

module tea_checker import tea_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_item_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_idx_t  cfg_index_i,
  input  word_t     cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  key_t      cipher_key;
  out_item_t expected_blocks[$];
  out_item_t oldest_block;
  int        mismatches;

  function automatic word_t tea_mix(word_t w, word_t s, word_t ka, word_t kb);
    return ((w << 4) + ka) ^ (w + s) ^ ((w >> 5) + kb);
  endfunction

  function automatic out_item_t tea_transform(in_item_t blk, key_t key);
    word_t     l;
    word_t     r;
    word_t     sum;
    out_item_t res;
    l = blk.block_left;
    r = blk.block_right;
    if (blk.kind == KindDecrypt) begin
      // Decryption walks the cycles backward, starting from the final round sum.
      sum = DecStart;
      for (int n = 0; n < NumCycles; n++) begin
        r   = r - tea_mix(l, sum, key.k2, key.k3);
        l   = l - tea_mix(r, sum, key.k0, key.k1);
        sum = sum - Delta;
      end
    end else begin
      sum = '0;
      for (int n = 0; n < NumCycles; n++) begin
        sum = sum + Delta;
        l   = l + tea_mix(r, sum, key.k0, key.k1);
        r   = r + tea_mix(l, sum, key.k2, key.k3);
      end
    end
    res.result_left  = l;
    res.result_right = r;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cipher_key = '0;
      expected_blocks.delete();
      mismatches = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgKey0: cipher_key.k0 = cfg_data_i;
          CfgKey1: cipher_key.k1 = cfg_data_i;
          CfgKey2: cipher_key.k2 = cfg_data_i;
          CfgKey3: cipher_key.k3 = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_blocks.push_back(tea_transform(in_item_i, cipher_key));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_blocks.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %h %h arrived with nothing expected",
                     $realtime, out_item_i.result_left, out_item_i.result_right);
          end
        end else begin
          oldest_block = expected_blocks.pop_front();
          if (out_item_i.result_left !== oldest_block.result_left ||
              out_item_i.result_right !== oldest_block.result_right) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch left exp %h got %h, right exp %h got %h", $realtime,
                       oldest_block.result_left, out_item_i.result_left,
                       oldest_block.result_right, out_item_i.result_right);
            end
          end
        end
      end
      pending_o    <= expected_blocks.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

FILE: tb/tea_block_cipher_tb.sv
// Top of the TEA block cipher testbench: clock, reset, stimulus and the final verdict.
// Depends on tea_pkg, the tea_block_cipher block and the tea_checker scoreboard.
`timescale 1ns / 1ps

module tea_block_cipher_tb;
  import tea_pkg::*;

  localparam int NumKeyWords = 4;
  localparam int CycleLimit  = 300000;
  localparam int RxAlways    = 0;
  localparam int RxRandom    = 1;
  localparam int RxStretch   = 2;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_t  cfg_index_i = '0;
  word_t     cfg_data_i = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int rx_mode = RxAlways;
  int rx_hold = 0;
  bit rx_stalled = 1'b0;
  bit tx_bursty = 1'b0;
  int burst_left = 0;

  tea_block_cipher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  tea_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver back-pressure: always ready, random stalls, or long alternating stretches.
  always @(negedge clk_i) begin
    case (rx_mode)
      RxRandom: out_ready_i <= ($urandom_range(0, 3) != 0);
      RxStretch: begin
        if (rx_hold == 0) begin
          rx_stalled = !rx_stalled;
          rx_hold = rx_stalled ? $urandom_range(1, 10) : $urandom_range(1, 16);
        end
        rx_hold--;
        out_ready_i <= !rx_stalled;
      end
      default: out_ready_i <= 1'b1;
    endcase
  end

  function automatic in_item_t make_block(logic kind, word_t l, word_t r);
    in_item_t blk;
    blk.kind        = kind;
    blk.block_left  = l;
    blk.block_right = r;
    return blk;
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_block(in_item_t blk);
    int gap;
    if (tx_bursty && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= blk;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops sending and waits until every predicted block has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, word_t data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Loads a full key and throws in one write to an unused index, which must be ignored.
  task automatic load_key(word_t k0, word_t k1, word_t k2, word_t k3);
    write_reg(CfgKey0, k0);
    write_reg(CfgKey1, k1);
    write_reg(CfgKey2, k2);
    write_reg(CfgKey3, k3);
    write_reg(cfg_idx_t'($urandom_range(NumKeyWords, 2 ** CfgIdxW - 1)), $urandom());
  endtask

  task automatic send_extremes();
    send_block(make_block(KindEncrypt, 32'h0000_0000, 32'h0000_0000));
    send_block(make_block(KindDecrypt, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_block(make_block(KindEncrypt, 32'h8000_0000, 32'h0000_0001));
    send_block(make_block(KindDecrypt, 32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with no idling; the all-zero key from reset is used first.
    send_extremes();
    send_block(make_block(KindDecrypt, 32'h0000_0000, 32'h0000_0000));
    send_block(make_block(KindEncrypt, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    drain();
    load_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_extremes();
    drain();
    load_key(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
    send_extremes();
    drain();
    load_key(32'h0000_0001, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_extremes();

    // Random part: a fresh key per phase, with the idling style rotating across phases.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0:       load_key('0, '0, '0, '0);
        1:       load_key('1, '1, '1, '1);
        default: load_key(pick_word(), pick_word(), pick_word(), pick_word());
      endcase
      rx_mode   = phase % 3;
      tx_bursty = (phase != 0);
      burst_left = 0;
      for (int n = 0; n < 125; n++) begin
        send_block(make_block(logic'($urandom_range(0, 1)), pick_word(), pick_word()));
      end
    end

    drain();
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
